### src/bevq_pkg.sv
// Shared types and constants for the button event qualifier.
// Used by bevq_track and button_event_qualifier; no dependencies.
`default_nettype none

package bevq_pkg;

    // Field widths
    localparam int BitsW   = 8;
    localparam int TimeW   = 32;
    localparam int PosW    = 3;
    localparam int ThreshW = 16;
    localparam int DirW    = 3;

    // Register file
    localparam int AddrW   = 5;
    localparam int DataW   = 32;

    // Register reset values
    localparam logic [ThreshW-1:0] LongPressReset = 16'd500;
    localparam logic [PosW-1:0]    ABitReset      = 3'd4;
    localparam logic [PosW-1:0]    BBitReset      = 3'd5;
    localparam logic [PosW-1:0]    UpBitReset     = 3'd0;
    localparam logic [PosW-1:0]    DownBitReset   = 3'd1;
    localparam logic [PosW-1:0]    LeftBitReset   = 3'd2;
    localparam logic [PosW-1:0]    RightBitReset  = 3'd3;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_LONG_PRESS = 3'd0,
        REG_A_BIT      = 3'd1,
        REG_B_BIT      = 3'd2,
        REG_UP_BIT     = 3'd3,
        REG_DOWN_BIT   = 3'd4,
        REG_LEFT_BIT   = 3'd5,
        REG_RIGHT_BIT  = 3'd6
    } reg_idx_t;

    // Direction codes
    typedef enum logic [DirW-1:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

    // Events from one button tracker
    typedef struct packed {
        logic press_ev;
        logic hold_ev;
    } btn_evt_t;

endpackage

`default_nettype wire

### src/bevq_track.sv
// Press and hold tracker for one button of the event qualifier.
// Depends on bevq_pkg for widths and the event struct.
`default_nettype none

module bevq_track (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic [bevq_pkg::BitsW-1:0]    cur_bits,
    input  wire logic [bevq_pkg::BitsW-1:0]    prev_bits,
    input  wire logic [bevq_pkg::PosW-1:0]     pos,
    input  wire logic [bevq_pkg::TimeW-1:0]    now_ms,
    input  wire logic [bevq_pkg::ThreshW-1:0]  long_press_ms,
    output bevq_pkg::btn_evt_t                 evt
);
    import bevq_pkg::*;

    logic             held_reg, held_next;
    logic [TimeW-1:0] start_reg, start_next;
    logic             cur_lvl, prev_lvl, press, release_edge;
    logic [TimeW-1:0] start_eff, elapsed;
    logic             hold_hit;

    // Edge detect and hold timer
    always_comb begin
        cur_lvl      = cur_bits[pos];
        prev_lvl     = prev_bits[pos];
        press        = cur_lvl & ~prev_lvl;
        release_edge = ~cur_lvl & prev_lvl;
        held_next    = press ? 1'b1 : (release_edge ? 1'b0 : held_reg);
        start_eff    = (press | release_edge) ? now_ms : start_reg;
        elapsed      = now_ms - start_eff;
        hold_hit     = held_next && (elapsed > {{(TimeW-ThreshW){1'b0}}, long_press_ms});
        start_next   = hold_hit ? now_ms : start_eff;
        evt.press_ev = press;
        evt.hold_ev  = hold_hit;
    end

    // Hold state; start time only matters while held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
        end else if (step) begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

### src/button_event_qualifier.sv
// Top level of the button event qualifier: APB registers, direction one-shot,
// output register. Depends on bevq_pkg and bevq_track.
`default_nettype none

// Takes one poll tick per transfer on the s_ side and returns one event transfer
// on the m_ side for each. A tick is qualified combinationally between the
// input port and the output register, so one tick is accepted every clock as
// long as the output register is empty or being drained; its event is registered
// in the next cycle. Throughput is one tick per cycle unless m_tready stalls.
// Registers sit at byte addresses 4*i: 0 long_press_ms, 4 A bit, 8 B bit,
// 12 up, 16 down, 20 left, 24 right. Write them only while the block is idle.
module button_event_qualifier (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bevq_pkg::AddrW-1:0]    paddr,
    input  wire logic [bevq_pkg::DataW-1:0]    pwdata,
    output logic      [bevq_pkg::DataW-1:0]    prdata,
    output logic                               pready,
    // Poll ticks
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [39:0]                   s_tdata,  // button_bits[7:0], now_ms[39:8]
    // Events
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [7:0]                    m_tdata   // a_short, a_long, b_short,
                                                         // b_long, direction[6:4], 0
);
    import bevq_pkg::*;

    // Configuration registers
    logic [ThreshW-1:0] long_press_reg;
    logic [PosW-1:0]    a_bit_reg, b_bit_reg;
    logic [PosW-1:0]    up_bit_reg, down_bit_reg, left_bit_reg, right_bit_reg;

    // Datapath
    logic               s_acc;
    logic [BitsW-1:0]   cur_bits;
    logic [TimeW-1:0]   now_ms;
    logic [BitsW-1:0]   last_bits_reg;
    logic               any_latched_reg, any_latched_next;
    logic [BitsW-1:0]   shot;
    dir_t               dir;
    btn_evt_t           a_evt, b_evt;
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg, m_tdata_next;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign cfg_idx  = reg_idx_t'(paddr[4:2]);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg <= LongPressReset;
            a_bit_reg      <= ABitReset;
            b_bit_reg      <= BBitReset;
            up_bit_reg     <= UpBitReset;
            down_bit_reg   <= DownBitReset;
            left_bit_reg   <= LeftBitReset;
            right_bit_reg  <= RightBitReset;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LONG_PRESS: long_press_reg <= pwdata[ThreshW-1:0];
                REG_A_BIT:      a_bit_reg      <= pwdata[PosW-1:0];
                REG_B_BIT:      b_bit_reg      <= pwdata[PosW-1:0];
                REG_UP_BIT:     up_bit_reg     <= pwdata[PosW-1:0];
                REG_DOWN_BIT:   down_bit_reg   <= pwdata[PosW-1:0];
                REG_LEFT_BIT:   left_bit_reg   <= pwdata[PosW-1:0];
                REG_RIGHT_BIT:  right_bit_reg  <= pwdata[PosW-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (cfg_idx)
            REG_LONG_PRESS: prdata = {{(DataW-ThreshW){1'b0}}, long_press_reg};
            REG_A_BIT:      prdata = {{(DataW-PosW){1'b0}}, a_bit_reg};
            REG_B_BIT:      prdata = {{(DataW-PosW){1'b0}}, b_bit_reg};
            REG_UP_BIT:     prdata = {{(DataW-PosW){1'b0}}, up_bit_reg};
            REG_DOWN_BIT:   prdata = {{(DataW-PosW){1'b0}}, down_bit_reg};
            REG_LEFT_BIT:   prdata = {{(DataW-PosW){1'b0}}, left_bit_reg};
            REG_RIGHT_BIT:  prdata = {{(DataW-PosW){1'b0}}, right_bit_reg};
            default:        prdata = '0;
        endcase
    end

    // Accept a tick whenever the output register is free or draining
    assign s_tready = ~m_tvalid_reg | m_tready;
    assign s_acc    = s_tvalid & s_tready;
    assign cur_bits = s_tdata[BitsW-1:0];
    assign now_ms   = s_tdata[BitsW+TimeW-1:BitsW];

    // Button trackers
    bevq_track u_track_a (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (s_acc),
        .cur_bits      (cur_bits),
        .prev_bits     (last_bits_reg),
        .pos           (a_bit_reg),
        .now_ms        (now_ms),
        .long_press_ms (long_press_reg),
        .evt           (a_evt)
    );

    bevq_track u_track_b (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (s_acc),
        .cur_bits      (cur_bits),
        .prev_bits     (last_bits_reg),
        .pos           (b_bit_reg),
        .now_ms        (now_ms),
        .long_press_ms (long_press_reg),
        .evt           (b_evt)
    );

    // Direction one-shot: arm on first tick with any bit set
    always_comb begin
        any_latched_next = (cur_bits != '0);
        shot = (cur_bits != '0 && !any_latched_reg) ? cur_bits : '0;
        if (shot[up_bit_reg]) begin
            dir = DIR_UP;
        end else if (shot[down_bit_reg]) begin
            dir = DIR_DOWN;
        end else if (shot[left_bit_reg]) begin
            dir = DIR_LEFT;
        end else if (shot[right_bit_reg]) begin
            dir = DIR_RIGHT;
        end else begin
            dir = DIR_NONE;
        end
        m_tdata_next = {1'b0, dir, b_evt.hold_ev, b_evt.press_ev,
                        a_evt.hold_ev, a_evt.press_ev};
    end

    // Tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_bits_reg   <= '0;
            any_latched_reg <= 1'b0;
        end else if (s_acc) begin
            last_bits_reg   <= cur_bits;
            any_latched_reg <= any_latched_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[6:4] <= DIR_RIGHT))
        else $error("direction code out of range");

    a_press_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[1]) && !(m_tdata_reg[2] && m_tdata_reg[3]))
        else $error("long event on the press tick");

    a_release_unlatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tdata[7:0] == 8'd0) |=> !any_latched_reg)
        else $error("one-shot latch held after all buttons released");

    a_dir_needs_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && any_latched_reg) |=> (m_tdata_reg[6:4] == DIR_NONE))
        else $error("direction reported while latch already armed");

endmodule

`default_nettype wire
